// ===== design/flyvpid_pkg.sv =====
// ----------------------------------------------------------------------------
// flyvpid_pkg
// Shared widths, register indexes, payload structs and state codes for the
// flywheel velocity PID block.
// ----------------------------------------------------------------------------
package flyvpid_pkg;

	// field widths
	localparam int VEL_W      = 16;
	localparam int SP_W       = 15;
	localparam int GAIN_W     = 16;
	localparam int DRV_W      = 12;
	localparam int ERR_W      = 17;
	localparam int DER_W      = 18;
	localparam int INT_W      = 32;
	// pid sum: gain times integral plus headroom for the other terms
	localparam int NUM_W      = INT_W + 18;

	// digit-serial multiply
	localparam int DIG_W      = 4;
	localparam int NDIG       = GAIN_W / DIG_W;
	localparam int DIG_CNT_W  = $clog2(NDIG);

	// divide by 2304: drop 8 bits, then reciprocal of 9
	localparam int DIV_SHIFT  = 8;
	localparam int QX_W       = 16;
	localparam int RECIP_W    = 16;
	localparam logic [RECIP_W-1:0] RECIP_9 = 16'd58255;
	localparam int RECIP_SH   = 19;
	localparam int LIM_W      = 25;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX = 3'd5;

	localparam logic [DRV_W-1:0] DRIVE_MIN_RST = 12'd256;
	localparam logic [DRV_W-1:0] DRIVE_MAX_RST = 12'd2048;

	// input request
	typedef struct packed {
		logic signed [VEL_W-1:0] measured_velocity;
		logic                    restart;
	} sample_t;

	// result request
	typedef struct packed {
		logic [DRV_W-1:0] drive_volts;
		logic             clamped_high;
		logic             clamped_low;
	} drive_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ERR,
		S_INTG,
		S_MAC,
		S_CMP,
		S_DIV
	} state_t;

	typedef enum logic [1:0] {
		TERM_P,
		TERM_D,
		TERM_I
	} term_t;

endpackage

// ===== design/flywheel_velocity_pid.sv =====
// ----------------------------------------------------------------------------
// flywheel_velocity_pid: PID velocity loop with clamped drive output
// A sample steps through the error, integral, multiply, compare and divide
// states before its result is registered; no new sample is taken until then.
// The gain multiply runs 4-bit digits through one shared multiply-add, 3 gains x 4 digits.
// Reset clears error history and integral, loads default gains and limits.
// ----------------------------------------------------------------------------
module flywheel_velocity_pid (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// sample channel
	input  logic                                    sample_valid,
	output logic                                    sample_stall,
	input  flyvpid_pkg::sample_t                    sample,
	// drive channel
	output logic                                    drive_valid,
	input  logic                                    drive_stall,
	output flyvpid_pkg::drive_t                     drive,
	// configuration write channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [flyvpid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [flyvpid_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// configuration registers
	logic [flyvpid_pkg::SP_W-1:0]   setpoint_q;
	logic [flyvpid_pkg::GAIN_W-1:0] gain_p_q;
	logic [flyvpid_pkg::GAIN_W-1:0] gain_i_q;
	logic [flyvpid_pkg::GAIN_W-1:0] gain_d_q;
	logic [flyvpid_pkg::DRV_W-1:0]  drive_min_q;
	logic [flyvpid_pkg::DRV_W-1:0]  drive_max_q;

	// loop state
	logic signed [flyvpid_pkg::ERR_W-1:0] prev_err_q;
	logic signed [flyvpid_pkg::INT_W-1:0] integ_q;

	// working registers
	flyvpid_pkg::state_t                  state_q, state_d;
	flyvpid_pkg::term_t                   term_q;
	logic [flyvpid_pkg::DIG_CNT_W-1:0]    dig_cnt_q;
	logic signed [flyvpid_pkg::VEL_W-1:0] vel_q;
	logic                                 restart_q;
	logic signed [flyvpid_pkg::ERR_W-1:0] e_q;
	logic signed [flyvpid_pkg::DER_W-1:0] d_q;
	logic signed [flyvpid_pkg::INT_W-1:0] sum_q;
	logic signed [flyvpid_pkg::NUM_W-1:0] mcand_q;
	logic [flyvpid_pkg::GAIN_W-1:0]       gain_sh_q;
	logic signed [flyvpid_pkg::NUM_W-1:0] acc_q;
	logic                                 hi_q;
	logic                                 lo_q;
	logic [flyvpid_pkg::QX_W-1:0]         x_q;
	flyvpid_pkg::drive_t                  drive_q;
	logic                                 drive_valid_q;

	// control
	logic sample_acc;
	logic out_ld;
	logic dig_last;

	// datapath nets
	logic signed [flyvpid_pkg::ERR_W-1:0]   prev_eff;
	logic signed [flyvpid_pkg::INT_W-1:0]   integ_eff;
	logic signed [flyvpid_pkg::ERR_W-1:0]   e_new;
	logic signed [flyvpid_pkg::DER_W-1:0]   d_new;
	logic signed [flyvpid_pkg::INT_W:0]     sum_wide;
	logic signed [flyvpid_pkg::INT_W-1:0]   sum_new;
	logic signed [flyvpid_pkg::NUM_W+flyvpid_pkg::DIG_W:0] pp;
	logic [flyvpid_pkg::DRV_W:0]            max_p1;
	logic [flyvpid_pkg::LIM_W-1:0]          hi_lim;
	logic [flyvpid_pkg::LIM_W-1:0]          lo_lim;
	logic [flyvpid_pkg::QX_W+flyvpid_pkg::RECIP_W-1:0] q_prod;
	logic [flyvpid_pkg::DRV_W-1:0]          quot;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q  <= '0;
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			drive_min_q <= flyvpid_pkg::DRIVE_MIN_RST;
			drive_max_q <= flyvpid_pkg::DRIVE_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				flyvpid_pkg::REG_SETPOINT:  setpoint_q  <= cfg_data[flyvpid_pkg::SP_W-1:0];
				flyvpid_pkg::REG_GAIN_P:    gain_p_q    <= cfg_data;
				flyvpid_pkg::REG_GAIN_I:    gain_i_q    <= cfg_data;
				flyvpid_pkg::REG_GAIN_D:    gain_d_q    <= cfg_data;
				flyvpid_pkg::REG_DRIVE_MIN: drive_min_q <= cfg_data[flyvpid_pkg::DRV_W-1:0];
				flyvpid_pkg::REG_DRIVE_MAX: drive_max_q <= cfg_data[flyvpid_pkg::DRV_W-1:0];
				default: ;
			endcase
		end
	end

	// error, derivative, saturating integral
	assign prev_eff  = restart_q ? '0 : prev_err_q;
	assign integ_eff = restart_q ? '0 : integ_q;
	assign e_new     = flyvpid_pkg::ERR_W'($signed({1'b0, setpoint_q})) -
		flyvpid_pkg::ERR_W'(vel_q);
	assign d_new     = flyvpid_pkg::DER_W'(e_q) - flyvpid_pkg::DER_W'(prev_eff);
	assign sum_wide  = (flyvpid_pkg::INT_W+1)'(integ_eff) + (flyvpid_pkg::INT_W+1)'(e_q);

	always_comb begin
		if (sum_wide[flyvpid_pkg::INT_W] != sum_wide[flyvpid_pkg::INT_W-1]) begin
			sum_new = sum_wide[flyvpid_pkg::INT_W] ?
				{1'b1, {(flyvpid_pkg::INT_W-1){1'b0}}} :
				{1'b0, {(flyvpid_pkg::INT_W-1){1'b1}}};
		end else begin
			sum_new = sum_wide[flyvpid_pkg::INT_W-1:0];
		end
	end

	// one digit of the current gain times its operand
	assign pp       = mcand_q * $signed({1'b0, gain_sh_q[flyvpid_pkg::DIG_W-1:0]});
	assign dig_last = (dig_cnt_q == flyvpid_pkg::DIG_CNT_W'(flyvpid_pkg::NDIG - 1));

	// clamp thresholds: (max+1)*2304 and min*2304
	assign max_p1 = {1'b0, drive_max_q} + 1'b1;
	assign hi_lim = flyvpid_pkg::LIM_W'({({max_p1, 3'b000} + {3'b000, max_p1}),
		{flyvpid_pkg::DIV_SHIFT{1'b0}}});
	assign lo_lim = flyvpid_pkg::LIM_W'({({1'b0, drive_min_q, 3'b000} + {4'b0000, drive_min_q}),
		{flyvpid_pkg::DIV_SHIFT{1'b0}}});

	// in-range quotient: (num >> 8) / 9 by reciprocal
	assign q_prod = x_q * flyvpid_pkg::RECIP_9;
	assign quot   = q_prod[flyvpid_pkg::RECIP_SH+flyvpid_pkg::DRV_W-1:flyvpid_pkg::RECIP_SH];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flyvpid_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		sample_acc   = 1'b0;
		out_ld       = 1'b0;
		case (state_q)
			flyvpid_pkg::S_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					sample_acc = 1'b1;
					state_d    = flyvpid_pkg::S_ERR;
				end
			end
			flyvpid_pkg::S_ERR:  state_d = flyvpid_pkg::S_INTG;
			flyvpid_pkg::S_INTG: state_d = flyvpid_pkg::S_MAC;
			flyvpid_pkg::S_MAC: begin
				if (dig_last && term_q == flyvpid_pkg::TERM_I) begin
					state_d = flyvpid_pkg::S_CMP;
				end
			end
			flyvpid_pkg::S_CMP:  state_d = flyvpid_pkg::S_DIV;
			flyvpid_pkg::S_DIV: begin
				if (!drive_valid_q || !drive_stall) begin
					out_ld  = 1'b1;
					state_d = flyvpid_pkg::S_IDLE;
				end
			end
			default: state_d = flyvpid_pkg::S_IDLE;
		endcase
	end

	// error history and integral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
		end else if (state_q == flyvpid_pkg::S_INTG) begin
			prev_err_q <= e_q;
			integ_q    <= sum_new;
		end
	end

	// digit-serial multiply-accumulate and clamp datapath
	always_ff @(posedge clk) begin
		if (sample_acc) begin
			vel_q     <= sample.measured_velocity;
			restart_q <= sample.restart;
		end
		case (state_q)
			flyvpid_pkg::S_ERR: begin
				e_q <= e_new;
			end
			flyvpid_pkg::S_INTG: begin
				d_q       <= d_new;
				sum_q     <= sum_new;
				mcand_q   <= flyvpid_pkg::NUM_W'(e_q);
				gain_sh_q <= gain_p_q;
				term_q    <= flyvpid_pkg::TERM_P;
				dig_cnt_q <= '0;
				acc_q     <= $signed(flyvpid_pkg::NUM_W'({setpoint_q,
					{flyvpid_pkg::DIV_SHIFT{1'b0}}}));
			end
			flyvpid_pkg::S_MAC: begin
				acc_q     <= acc_q + pp[flyvpid_pkg::NUM_W-1:0];
				dig_cnt_q <= dig_cnt_q + 1'b1;
				if (dig_last) begin
					// move on to the next gain term
					case (term_q)
						flyvpid_pkg::TERM_P: begin
							term_q    <= flyvpid_pkg::TERM_D;
							mcand_q   <= flyvpid_pkg::NUM_W'(d_q);
							gain_sh_q <= gain_d_q;
						end
						flyvpid_pkg::TERM_D: begin
							term_q    <= flyvpid_pkg::TERM_I;
							mcand_q   <= flyvpid_pkg::NUM_W'(sum_q);
							gain_sh_q <= gain_i_q;
						end
						default: ;
					endcase
				end else begin
					mcand_q   <= mcand_q <<< flyvpid_pkg::DIG_W;
					gain_sh_q <= gain_sh_q >> flyvpid_pkg::DIG_W;
				end
			end
			flyvpid_pkg::S_CMP: begin
				hi_q <= (acc_q >= $signed(flyvpid_pkg::NUM_W'(hi_lim)));
				lo_q <= (acc_q <  $signed(flyvpid_pkg::NUM_W'(lo_lim)));
				x_q  <= acc_q[flyvpid_pkg::QX_W+flyvpid_pkg::DIV_SHIFT-1:flyvpid_pkg::DIV_SHIFT];
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_valid_q <= 1'b0;
		end else if (out_ld) begin
			drive_valid_q <= 1'b1;
		end else if (!drive_stall) begin
			drive_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			if (hi_q) begin
				drive_q.drive_volts <= drive_max_q;
			end else if (lo_q) begin
				drive_q.drive_volts <= drive_min_q;
			end else begin
				drive_q.drive_volts <= quot;
			end
			drive_q.clamped_high <= hi_q;
			drive_q.clamped_low  <= !hi_q && lo_q;
		end
	end

	assign drive_valid = drive_valid_q;
	assign drive       = drive_q;

`ifndef SYNTHESIS
	// never both clamp flags
	a_one_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> !(drive.clamped_high && drive.clamped_low))
		else $error("both clamp flags set");

	// high clamp returns the upper limit
	a_hi_value: assert property (@(posedge clk) disable iff (!arst_n)
		(drive_valid && drive.clamped_high) |-> drive.drive_volts == drive_max_q)
		else $error("high clamp value differs from drive_max");

	// unclamped drive lies within the limits
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(drive_valid && !drive.clamped_high && !drive.clamped_low) |->
		(drive.drive_volts >= drive_min_q && drive.drive_volts <= drive_max_q))
		else $error("unclamped drive outside limits");

	// multiply ends only after the integral term
	a_mac_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == flyvpid_pkg::S_MAC && state_d != flyvpid_pkg::S_MAC) |->
		(term_q == flyvpid_pkg::TERM_I && dig_last))
		else $error("multiply left before last term");
`endif

endmodule

// ===== tb/flywheel_velocity_pid_tb.sv =====
// ----------------------------------------------------------------------------
// flywheel_velocity_pid_tb: self-checking bench for the flywheel PID block
// Drives velocity samples with random source gaps and sink stalls, predicts
// each clamped drive result from a bit-exact software copy of the loop, and
// compares every returned drive request field by field, in order.
// ----------------------------------------------------------------------------
module flywheel_velocity_pid_tb;

	localparam int     CLK_HI         = 6;
	localparam int     CLK_LO         = 6;
	localparam int     RESET_CYCLES   = 10;
	localparam int     SETTLE_CYCLES  = 40;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     MAX_REPORTS    = 10;
	localparam int     SAT_SAMPLES    = 200;
	localparam int     RAND_PHASES    = 8;
	localparam int     PHASE_SAMPLES  = 170;
	localparam longint VOLT_DIVISOR   = 2304;	// 9 * 256
	localparam longint INTEG_MAX      = (64'sd1 <<< (flyvpid_pkg::INT_W - 1)) - 1;
	localparam longint INTEG_MIN      = -INTEG_MAX - 1;
	// indexes past the register list, writes there must be ignored
	localparam logic [flyvpid_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_A =
		flyvpid_pkg::REG_DRIVE_MAX + 3'd1;
	localparam logic [flyvpid_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_B =
		flyvpid_pkg::REG_DRIVE_MAX + 3'd2;

	logic                                clk;
	logic                                arst_n       = 1'b0;
	logic                                sample_valid = 1'b0;
	logic                                sample_stall;
	flyvpid_pkg::sample_t                sample       = '0;
	logic                                drive_valid;
	logic                                drive_stall  = 1'b0;
	flyvpid_pkg::drive_t                 drive;
	logic                                cfg_valid    = 1'b0;
	logic                                cfg_ready;
	logic [flyvpid_pkg::CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [flyvpid_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

	// loop registers and state as the block should hold them
	logic [flyvpid_pkg::SP_W-1:0]   cur_setpoint = '0;
	logic [flyvpid_pkg::GAIN_W-1:0] cur_kp       = '0;
	logic [flyvpid_pkg::GAIN_W-1:0] cur_ki       = '0;
	logic [flyvpid_pkg::GAIN_W-1:0] cur_kd       = '0;
	logic [flyvpid_pkg::DRV_W-1:0]  cur_min      = flyvpid_pkg::DRIVE_MIN_RST;
	logic [flyvpid_pkg::DRV_W-1:0]  cur_max      = flyvpid_pkg::DRIVE_MAX_RST;
	longint                         last_error   = 0;
	longint                         error_sum    = 0;

	flyvpid_pkg::sample_t pending_samples[$];
	flyvpid_pkg::drive_t  expected_drives[$];

	int samples_offered = 0;
	int samples_taken   = 0;
	int drives_checked  = 0;
	int cfg_writes      = 0;
	int fail_count      = 0;
	int idle_cycles     = 0;
	int send_gap        = 0;
	int stall_left      = 0;
	int send_idle_pct   = 0;
	int stall_pct       = 0;

	flywheel_velocity_pid dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.drive        (drive),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#CLK_HI;
		clk = 1'b0;
		#CLK_LO;
	end

	// register write as the block decodes it
	function automatic void apply_reg(logic [flyvpid_pkg::CFG_IDX_W-1:0] idx,
		logic [flyvpid_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			flyvpid_pkg::REG_SETPOINT:  cur_setpoint = data[flyvpid_pkg::SP_W-1:0];
			flyvpid_pkg::REG_GAIN_P:    cur_kp = data[flyvpid_pkg::GAIN_W-1:0];
			flyvpid_pkg::REG_GAIN_I:    cur_ki = data[flyvpid_pkg::GAIN_W-1:0];
			flyvpid_pkg::REG_GAIN_D:    cur_kd = data[flyvpid_pkg::GAIN_W-1:0];
			flyvpid_pkg::REG_DRIVE_MIN: cur_min = data[flyvpid_pkg::DRV_W-1:0];
			flyvpid_pkg::REG_DRIVE_MAX: cur_max = data[flyvpid_pkg::DRV_W-1:0];
			default: ;
		endcase
	endfunction

	// one PID step: error, derivative, saturating integral, clamped drive
	function automatic flyvpid_pkg::drive_t predict_drive(flyvpid_pkg::sample_t s);
		longint err;
		longint der;
		longint num;
		flyvpid_pkg::drive_t r;
		if (s.restart) begin
			last_error = 0;
			error_sum = 0;
		end
		err = longint'(cur_setpoint) - longint'($signed(s.measured_velocity));
		der = err - last_error;
		error_sum = error_sum + err;
		if (error_sum > INTEG_MAX)
			error_sum = INTEG_MAX;
		else if (error_sum < INTEG_MIN)
			error_sum = INTEG_MIN;
		num = longint'(cur_setpoint) * 256 + longint'(cur_kp) * err
			+ longint'(cur_kd) * der + longint'(cur_ki) * error_sum;
		r = '0;
		// high limit is tested first, so where both tests hold (inverted limits) the result is drive_max
		if (num >= (longint'(cur_max) + 1) * VOLT_DIVISOR) begin
			r.drive_volts = cur_max;
			r.clamped_high = 1'b1;
		end else if (num < longint'(cur_min) * VOLT_DIVISOR) begin
			r.drive_volts = cur_min;
			r.clamped_low = 1'b1;
		end else begin
			r.drive_volts = flyvpid_pkg::DRV_W'(num / VOLT_DIVISOR);
		end
		last_error = err;
		return r;
	endfunction

	// sample source: holds a stalled request, otherwise idles in bursts or sends
	always @(negedge clk) begin
		if (sample_valid && samples_taken != samples_offered) begin
			// request still waiting, payload held
		end else if (send_gap > 0) begin
			sample_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
			sample_valid <= 1'b0;
			send_gap <= $urandom_range(0, 14);
		end else if (pending_samples.size() != 0) begin
			sample <= pending_samples.pop_front();
			sample_valid <= 1'b1;
			samples_offered <= samples_offered + 1;
		end else begin
			sample_valid <= 1'b0;
		end
	end

	// drive sink: stalls in bursts of random length
	always @(negedge clk) begin
		if (stall_left > 0) begin
			drive_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
			drive_stall <= 1'b1;
			stall_left <= $urandom_range(0, 14);
		end else begin
			drive_stall <= 1'b0;
		end
	end

	// monitor: tracks config writes, predicts on sample accept, checks drives
	always @(posedge clk) begin : monitor
		flyvpid_pkg::drive_t want;
		logic                moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_index, cfg_data);
				cfg_writes <= cfg_writes + 1;
				moved = 1'b1;
			end
			if (sample_valid && !sample_stall) begin
				expected_drives.push_back(predict_drive(sample));
				samples_taken <= samples_taken + 1;
				moved = 1'b1;
			end
			if (drive_valid && !drive_stall) begin
				moved = 1'b1;
				drives_checked <= drives_checked + 1;
				if (expected_drives.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected drive request: volts=%0d high=%b low=%b",
							drive.drive_volts, drive.clamped_high, drive.clamped_low);
				end else begin
					want = expected_drives.pop_front();
					if (drive.drive_volts !== want.drive_volts
						|| drive.clamped_high !== want.clamped_high
						|| drive.clamped_low !== want.clamped_low) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("drive mismatch #%0d: exp %0d/%b/%b, got %0d/%b/%b",
								drives_checked, want.drive_volts, want.clamped_high,
								want.clamped_low, drive.drive_volts, drive.clamped_high,
								drive.clamped_low);
					end
				end
			end
			// watchdog on a stuck handshake
			if (moved) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles, %0d drives outstanding",
					idle_cycles, expected_drives.size());
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// single register write, called at a falling edge; leaves valid high
	task automatic write_reg(logic [flyvpid_pkg::CFG_IDX_W-1:0] idx,
		logic [flyvpid_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// full register set plus one unmapped index; upper data bits may carry junk
	task automatic program_regs(logic [flyvpid_pkg::CFG_DATA_W-1:0] sp,
		logic [flyvpid_pkg::CFG_DATA_W-1:0] kp,
		logic [flyvpid_pkg::CFG_DATA_W-1:0] ki, logic [flyvpid_pkg::CFG_DATA_W-1:0] kd,
		logic [flyvpid_pkg::CFG_DATA_W-1:0] lo, logic [flyvpid_pkg::CFG_DATA_W-1:0] hi);
		write_reg(flyvpid_pkg::REG_SETPOINT, sp);
		write_reg(flyvpid_pkg::REG_GAIN_P, kp);
		write_reg(flyvpid_pkg::REG_GAIN_I, ki);
		write_reg(flyvpid_pkg::REG_GAIN_D, kd);
		write_reg(flyvpid_pkg::REG_DRIVE_MIN, lo);
		write_reg(flyvpid_pkg::REG_DRIVE_MAX, hi);
		write_reg($urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B,
			flyvpid_pkg::CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic push_sample(logic [flyvpid_pkg::VEL_W-1:0] vel, logic restart);
		flyvpid_pkg::sample_t s;
		s.measured_velocity = vel;
		s.restart = restart;
		pending_samples.push_back(s);
	endtask

	// block idle: all samples taken, all drives back, pipeline flushed
	task automatic drain();
		do @(negedge clk);
		while (!(pending_samples.size() == 0 && samples_taken == samples_offered
			&& expected_drives.size() == 0));
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly near the setpoint so the drive lands inside the limits
	function automatic logic [flyvpid_pkg::VEL_W-1:0] random_velocity();
		int sel;
		int span;
		sel = $urandom_range(0, 9);
		span = 1 << $urandom_range(2, 11);
		if (sel < 7)
			return flyvpid_pkg::VEL_W'(int'(cur_setpoint)
				+ int'($urandom_range(0, 2 * span)) - span);
		else if (sel < 9)
			return flyvpid_pkg::VEL_W'($urandom);
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return flyvpid_pkg::VEL_W'(-25600);
			default: return flyvpid_pkg::VEL_W'(25600);
		endcase
	endfunction

	task automatic randomize_regs(logic inverted, logic wide_gains);
		logic [flyvpid_pkg::DRV_W-1:0] lo;
		logic [flyvpid_pkg::DRV_W-1:0] hi;
		if (inverted) begin
			lo = flyvpid_pkg::DRV_W'($urandom_range(2000, 3072));
			hi = flyvpid_pkg::DRV_W'($urandom_range(0, 1000));
		end else begin
			lo = flyvpid_pkg::DRV_W'($urandom_range(0, 1024));
			hi = lo + flyvpid_pkg::DRV_W'($urandom_range(0, 2048));
		end
		program_regs({1'($urandom_range(0, 1)), flyvpid_pkg::SP_W'($urandom_range(0, 25600))},
			wide_gains ? flyvpid_pkg::CFG_DATA_W'($urandom)
				: flyvpid_pkg::CFG_DATA_W'($urandom_range(0, 512)),
			wide_gains ? flyvpid_pkg::CFG_DATA_W'($urandom)
				: flyvpid_pkg::CFG_DATA_W'($urandom_range(0, 24)),
			wide_gains ? flyvpid_pkg::CFG_DATA_W'($urandom)
				: flyvpid_pkg::CFG_DATA_W'($urandom_range(0, 512)),
			{4'($urandom_range(0, 15)), lo}, {4'($urandom_range(0, 15)), hi});
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// reset values: zero gains and setpoint, drive pinned to the low limit
		push_sample(16'h0000, 1'b0);
		push_sample(16'h7fff, 1'b0);
		push_sample(16'h8000, 1'b1);
		drain();

		// directed: field extremes, restart, both clamps and the linear region
		program_regs(16'd12800, 16'h0100, 16'h0008, 16'h0040, 16'd256, 16'd2048);
		push_sample(16'd12800, 1'b1);
		push_sample(16'd12700, 1'b0);
		push_sample(16'd12900, 1'b0);
		push_sample(16'd0, 1'b0);
		push_sample(16'd25600, 1'b0);
		push_sample(flyvpid_pkg::VEL_W'(-25600), 1'b0);
		push_sample(16'h7fff, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h5555, 1'b0);
		push_sample(16'haaaa, 1'b0);
		push_sample(16'h8000, 1'b1);
		push_sample(16'h7fff, 1'b1);
		push_sample(16'd12800, 1'b0);
		drain();

		// low limit above high limit: high test wins
		program_regs(16'd12800, 16'h0100, 16'h0000, 16'h0000, 16'd3000, 16'd100);
		push_sample(16'd12800, 1'b1);
		push_sample(16'h7fff, 1'b0);
		push_sample(16'd12800, 1'b1);
		drain();

		// all-ones setpoint, gains and high limit, masked to field widths
		program_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'hffff);
		push_sample(16'h7fff, 1'b1);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h7fff, 1'b0);
		push_sample(16'h0000, 1'b1);
		drain();

		// zero limits and zero gains: drive exactly zero, no clamp flag
		program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hf000, 16'hf000);
		push_sample(16'h1234, 1'b0);
		push_sample(16'h8000, 1'b1);
		drain();

		// integral windup: largest error held so the integral grows every step
		// while the drive stays pinned at the high clamp
		program_regs(16'h7fff, 16'h0000, 16'h0001, 16'h0000, 16'd0, 16'd3072);
		push_sample(16'h8000, 1'b1);
		for (int i = 1; i < SAT_SAMPLES; i++)
			push_sample(16'h8000, 1'b0);
		drain();

		// random phases, the last one without idling on either side
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == RAND_PHASES - 1) begin
				send_idle_pct = 0;
				stall_pct = 0;
			end else begin
				send_idle_pct = 10 * $urandom_range(0, 2);
				stall_pct = 10 * $urandom_range(0, 2);
			end
			randomize_regs(p == 2 || p == 5, p % 3 == 1);
			for (int i = 0; i < PHASE_SAMPLES; i++)
				push_sample(random_velocity(), $urandom_range(0, 19) == 0);
			drain();
		end

		$display("run covered %0d samples and %0d drive results over %0d register writes,",
			samples_taken, drives_checked, cfg_writes);
		$display("including integral windup, inverted limits and all-ones registers; %0d mismatches",
			fail_count);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
